// ===== hdl/alucc_pkg.sv =====
// Shared operation codes, constants and flag type of the 8/16-bit ALU with condition codes.
package alucc_pkg;

   // Operation codes carried by the action field of an item.
   localparam int unsigned ACTION_WIDTH = 5;

   localparam logic [ACTION_WIDTH-1:0] ACT_ADD8   = 5'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_SUB8   = 5'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_ADD16  = 5'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_SUB16  = 5'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_AND8   = 5'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_OR8    = 5'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_XOR8   = 5'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_PASS8  = 5'd7;
   localparam logic [ACTION_WIDTH-1:0] ACT_PASS16 = 5'd8;
   localparam logic [ACTION_WIDTH-1:0] ACT_INC8   = 5'd9;
   localparam logic [ACTION_WIDTH-1:0] ACT_DEC8   = 5'd10;
   localparam logic [ACTION_WIDTH-1:0] ACT_ASL8   = 5'd11;
   localparam logic [ACTION_WIDTH-1:0] ACT_ASL16  = 5'd12;
   localparam logic [ACTION_WIDTH-1:0] ACT_ASR8   = 5'd13;
   localparam logic [ACTION_WIDTH-1:0] ACT_LSR8   = 5'd14;
   localparam logic [ACTION_WIDTH-1:0] ACT_LSR16  = 5'd15;
   localparam logic [ACTION_WIDTH-1:0] ACT_ROL8   = 5'd16;
   localparam logic [ACTION_WIDTH-1:0] ACT_ROR8   = 5'd17;
   localparam logic [ACTION_WIDTH-1:0] ACT_DAA    = 5'd18;

   // Data widths.
   localparam int unsigned WORD_WIDTH = 16;
   localparam int unsigned BYTE_WIDTH = 8;

   // Overflow markers of increment and decrement.
   localparam logic [BYTE_WIDTH-1:0] MOST_NEGATIVE_8 = 8'h80;
   localparam logic [BYTE_WIDTH-1:0] MOST_POSITIVE_8 = 8'h7F;

   // Decimal adjust corrections and digit limits.
   localparam logic [BYTE_WIDTH-1:0] DAA_LOW_ADJUST  = 8'h06;
   localparam logic [BYTE_WIDTH-1:0] DAA_HIGH_ADJUST = 8'h60;
   localparam logic [3:0]            BCD_NINE        = 4'd9;
   localparam logic [3:0]            BCD_EIGHT       = 4'd8;

   // Condition code register: half carry, negative, zero, overflow, carry.
   typedef struct packed {
      logic h;
      logic n;
      logic z;
      logic v;
      logic c;
   } flags_type;

endpackage

// ===== hdl/alucc_core.sv =====
// Combinational datapath of the ALU: one operation and its condition code update.
module alucc_core
   import alucc_pkg::*;
(
   input  logic [ACTION_WIDTH-1:0] action,
   input  logic [WORD_WIDTH-1:0]   operand_a,
   input  logic [WORD_WIDTH-1:0]   operand_b,
   input  flags_type               flags_in,
   output logic [WORD_WIDTH-1:0]   result,
   output flags_type               flags_out
);

   // Operation select, with the flag rules of each operation.
   always_comb begin
      logic [BYTE_WIDTH-1:0] a8;
      logic [BYTE_WIDTH-1:0] b8;
      logic [BYTE_WIDTH:0]   sum8;
      logic [BYTE_WIDTH:0]   dif8;
      logic [WORD_WIDTH:0]   sum16;
      logic [WORD_WIDTH:0]   dif16;
      logic [4:0]            nib_sum;
      logic [BYTE_WIDTH-1:0] step8;
      logic [BYTE_WIDTH-1:0] adjust;
      logic [BYTE_WIDTH:0]   daa_sum;
      logic [3:0]            lo_digit;
      logic [3:0]            hi_digit;
      logic                  set_nz;
      logic                  wide;

      a8       = operand_a[BYTE_WIDTH-1:0];
      b8       = operand_b[BYTE_WIDTH-1:0];
      sum8     = {1'b0, a8} + {1'b0, b8};
      dif8     = {1'b0, a8} - {1'b0, b8};
      sum16    = {1'b0, operand_a} + {1'b0, operand_b};
      dif16    = {1'b0, operand_a} - {1'b0, operand_b};
      nib_sum  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
      lo_digit = a8[3:0];
      hi_digit = a8[7:4];
      step8    = '0;
      adjust   = '0;
      daa_sum  = '0;
      result   = '0;
      flags_out = flags_in;
      set_nz   = 1'b1;
      wide     = 1'b0;

      case (action)
         ACT_ADD8: begin
            result      = {8'h00, sum8[BYTE_WIDTH-1:0]};
            flags_out.h = nib_sum[4];
            flags_out.c = sum8[BYTE_WIDTH];
            flags_out.v = (a8[7] & b8[7] & ~sum8[7]) | (~a8[7] & ~b8[7] & sum8[7]);
         end
         ACT_SUB8: begin
            result      = {8'h00, dif8[BYTE_WIDTH-1:0]};
            flags_out.c = dif8[BYTE_WIDTH];
            flags_out.v = (a8[7] & ~b8[7] & ~dif8[7]) | (~a8[7] & b8[7] & dif8[7]);
         end
         ACT_ADD16: begin
            wide        = 1'b1;
            result      = sum16[WORD_WIDTH-1:0];
            flags_out.c = sum16[WORD_WIDTH];
            flags_out.v = (operand_a[15] & operand_b[15] & ~sum16[15]) |
                          (~operand_a[15] & ~operand_b[15] & sum16[15]);
         end
         ACT_SUB16: begin
            wide        = 1'b1;
            result      = dif16[WORD_WIDTH-1:0];
            flags_out.c = dif16[WORD_WIDTH];
            flags_out.v = (operand_a[15] & ~operand_b[15] & ~dif16[15]) |
                          (~operand_a[15] & operand_b[15] & dif16[15]);
         end
         ACT_AND8: begin
            result      = {8'h00, a8 & b8};
            flags_out.v = 1'b0;
         end
         ACT_OR8: begin
            result      = {8'h00, a8 | b8};
            flags_out.v = 1'b0;
         end
         ACT_XOR8: begin
            result      = {8'h00, a8 ^ b8};
            flags_out.v = 1'b0;
         end
         ACT_PASS8: begin
            result      = {8'h00, a8};
            flags_out.v = 1'b0;
         end
         ACT_PASS16: begin
            wide        = 1'b1;
            result      = operand_a;
            flags_out.v = 1'b0;
         end
         ACT_INC8: begin
            step8       = a8 + 8'd1;
            result      = {8'h00, step8};
            flags_out.v = (step8 == MOST_NEGATIVE_8);
         end
         ACT_DEC8: begin
            step8       = a8 - 8'd1;
            result      = {8'h00, step8};
            flags_out.v = (step8 == MOST_POSITIVE_8);
         end
         ACT_ASL8: begin
            result      = {8'h00, a8[6:0], 1'b0};
            flags_out.c = a8[7];
            flags_out.v = a8[6] ^ a8[7];
         end
         ACT_ASL16: begin
            wide        = 1'b1;
            result      = {operand_a[14:0], 1'b0};
            flags_out.c = operand_a[15];
            flags_out.v = operand_a[14] ^ operand_a[15];
         end
         ACT_ASR8: begin
            result      = {8'h00, a8[7], a8[7:1]};
            flags_out.c = a8[0];
            flags_out.v = a8[7] ^ a8[0];
         end
         ACT_LSR8: begin
            result      = {8'h00, 1'b0, a8[7:1]};
            flags_out.c = a8[0];
            flags_out.v = a8[0];
         end
         ACT_LSR16: begin
            wide        = 1'b1;
            result      = {1'b0, operand_a[15:1]};
            flags_out.c = operand_a[0];
            flags_out.v = operand_a[0];
         end
         ACT_ROL8: begin
            result      = {8'h00, a8[6:0], flags_in.c};
            flags_out.c = a8[7];
            flags_out.v = a8[6] ^ a8[7];
         end
         ACT_ROR8: begin
            result      = {8'h00, flags_in.c, a8[7:1]};
            flags_out.c = a8[0];
            flags_out.v = flags_in.c ^ a8[0];
         end
         ACT_DAA: begin
            // The low correction fixes the units digit, the high one the tens digit.
            if (flags_in.h || (lo_digit > BCD_NINE)) begin
               adjust = adjust | DAA_LOW_ADJUST;
            end
            if (flags_in.c || (hi_digit > BCD_NINE) ||
                ((hi_digit > BCD_EIGHT) && (lo_digit > BCD_NINE))) begin
               adjust = adjust | DAA_HIGH_ADJUST;
            end
            daa_sum     = {1'b0, a8} + {1'b0, adjust};
            result      = {8'h00, daa_sum[BYTE_WIDTH-1:0]};
            flags_out.c = flags_in.c | daa_sum[BYTE_WIDTH];
         end
         default: begin
            // Unused codes give zero and leave every flag as it was.
            set_nz = 1'b0;
         end
      endcase

      // Sign and zero follow the operation width; logical right shifts clear the sign.
      if (set_nz) begin
         if (wide) begin
            flags_out.n = result[WORD_WIDTH-1];
            flags_out.z = (result == '0);
         end else begin
            flags_out.n = result[BYTE_WIDTH-1];
            flags_out.z = (result[BYTE_WIDTH-1:0] == '0);
         end
         if ((action == ACT_LSR8) || (action == ACT_LSR16)) begin
            flags_out.n = 1'b0;
         end
      end
   end

endmodule

// ===== hdl/alu_8_16_with_condition_codes.sv =====
// Top level of the 8/16-bit ALU with condition codes: input register, datapath, result register.
// An accepted item is captured in the input register; its result is loaded into the result
// register and shown on the rsp_ ports, marked by rsp_strobe, where the receiver takes it.
// Throughput: one item per cycle; busy is held low, as the input and result registers are
// each one stage deep and the receiver always takes a result in its cycle.
// Reset: synchronous and active high; it clears both valid stages, so no result is shown.
module alu_8_16_with_condition_codes
   import alucc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [WORD_WIDTH-1:0]   req_operand_a,
   input  logic [WORD_WIDTH-1:0]   req_operand_b,
   input  logic                    req_half_carry_in,
   input  logic                    req_negative_in,
   input  logic                    req_zero_in,
   input  logic                    req_overflow_in,
   input  logic                    req_carry_in,
   output logic                    rsp_strobe,
   output logic [WORD_WIDTH-1:0]   rsp_result,
   output logic                    rsp_half_carry_out,
   output logic                    rsp_negative_out,
   output logic                    rsp_zero_out,
   output logic                    rsp_overflow_out,
   output logic                    rsp_carry_out
);

   logic                    accept;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [ACTION_WIDTH-1:0] action_ff;
   logic [WORD_WIDTH-1:0]   operand_a_ff;
   logic [WORD_WIDTH-1:0]   operand_b_ff;
   flags_type               flags_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [WORD_WIDTH-1:0]   result_ff;
   logic [WORD_WIDTH-1:0]   result_in;
   flags_type               out_flags_ff;
   flags_type               out_flags_in;

   // The pipeline never stalls, so an item is taken whenever start is raised.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Valid bits of the input and result stages.
   assign in_valid_in  = accept;
   assign out_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register: the item is captured when it is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff    <= req_action;
         operand_a_ff <= req_operand_a;
         operand_b_ff <= req_operand_b;
         flags_ff     <= '{h: req_half_carry_in, n: req_negative_in, z: req_zero_in,
                           v: req_overflow_in, c: req_carry_in};
      end
   end

   // Operation and flag update.
   alucc_core u_core (
      .action    (action_ff),
      .operand_a (operand_a_ff),
      .operand_b (operand_b_ff),
      .flags_in  (flags_ff),
      .result    (result_in),
      .flags_out (out_flags_in)
   );

   // Result register, loaded from a valid input stage.
   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         result_ff    <= result_in;
         out_flags_ff <= out_flags_in;
      end
   end

   assign rsp_strobe         = out_valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_half_carry_out = out_flags_ff.h;
   assign rsp_negative_out   = out_flags_ff.n;
   assign rsp_zero_out       = out_flags_ff.z;
   assign rsp_overflow_out   = out_flags_ff.v;
   assign rsp_carry_out      = out_flags_ff.c;

`ifndef SYNTHESIS
   // Every accepted item gives a result once it has passed the input and result registers.
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted item gave no result");

   // No result appears without an accepted item ahead of it in the input and result registers.
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result without an accepted item");

   // Unused operation codes give zero and keep the incoming negative and carry flags.
   a_unused_code_passes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_action, 2) > ACT_DAA)) |->
         ((rsp_result == '0) && (rsp_negative_out == $past(req_negative_in, 2)) &&
          (rsp_carry_out == $past(req_carry_in, 2))))
      else $error("unused code changed result or flags");

   // Logical right shifts always clear the negative flag.
   a_lsr_clears_n: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (($past(req_action, 2) == ACT_LSR8) ||
                      ($past(req_action, 2) == ACT_LSR16))) |-> !rsp_negative_out)
      else $error("logical shift right left N set");

   // Byte operations give a zero high byte.
   a_byte_high_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_action, 2) != ACT_ADD16) &&
       ($past(req_action, 2) != ACT_SUB16) && ($past(req_action, 2) != ACT_PASS16) &&
       ($past(req_action, 2) != ACT_ASL16) && ($past(req_action, 2) != ACT_LSR16)) |->
         (rsp_result[WORD_WIDTH-1:BYTE_WIDTH] == '0))
      else $error("byte operation gave a non-zero high byte");
`endif

endmodule
